// ----- sv/hdrx_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the header tag value extractor.
// No dependencies; used by every module of the block by scoped names.
package hdrx_pkg;

  // Transaction modes on the input channel
  localparam logic [1:0] MODE_DATA  = 2'd0;
  localparam logic [1:0] MODE_START = 2'd1;
  localparam logic [1:0] MODE_END   = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_TAG_LENGTH = 2'd0;
  localparam logic [1:0] CFG_TAG_LOW    = 2'd1;
  localparam logic [1:0] CFG_TAG_HIGH   = 2'd2;

  // Delimiter bytes
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_CR    = 8'h0D;

  // Width of a tag byte position, enough for positions 0..63
  localparam int TAG_IDX_W = 6;

  typedef enum logic [1:0] {
    KIND_BYTE      = 2'd0,
    KIND_COMPLETE  = 2'd1,
    KIND_NOT_FOUND = 2'd2,
    KIND_TRUNCATED = 2'd3
  } kind_e;

  // Window control from the sequencer
  typedef struct packed {
    logic push;
    logic clear;
  } win_ctrl_t;

  // One result produced by the sequencer
  typedef struct packed {
    logic       valid;
    kind_e      kind;
    logic [7:0] value;
  } res_t;

  // Tag byte at a position; positions past the sixteen held bytes read zero
  function automatic logic [7:0] tag_byte(input logic [63:0] lo, input logic [63:0] hi,
                                          input logic [TAG_IDX_W-1:0] idx);
    logic [7:0] b;
    if (idx[TAG_IDX_W-1:4] != '0) begin
      b = 8'h00;
    end else if (idx[3]) begin
      b = hi[{idx[2:0], 3'b000} +: 8];
    end else begin
      b = lo[{idx[2:0], 3'b000} +: 8];
    end
    return b;
  endfunction

endpackage

// ----- sv/hdrx_window.sv -----
`timescale 1ns / 1ps
// Recent byte window, byte counter and parallel tag compare.
// Depends on hdrx_pkg.
module hdrx_window #(
  parameter int TAG_MAX = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  hdrx_pkg::win_ctrl_t ctrl_i,
  input  logic [7:0]          byte_i,
  input  logic [4:0]          tag_length_i,
  input  logic [63:0]         tag_low_i,
  input  logic [63:0]         tag_high_i,
  output logic                match_o
);

  localparam int CNT_W = $clog2(TAG_MAX + 1);

  logic [7:0]       win_q [TAG_MAX];
  logic [7:0]       win_d [TAG_MAX];
  logic [CNT_W-1:0] seen_q;
  logic [CNT_W-1:0] seen_d;
  logic [CNT_W-1:0] eff_len;
  logic [TAG_MAX-1:0] hit;

  // Clamp the programmed length into 1..TAG_MAX
  always_comb begin
    if (tag_length_i == 5'd0) begin
      eff_len = CNT_W'(1);
    end else if (32'(tag_length_i) > TAG_MAX) begin
      eff_len = CNT_W'(TAG_MAX);
    end else begin
      eff_len = CNT_W'(tag_length_i);
    end
  end

  // Window after the incoming byte is shifted in, entry 0 newest
  always_comb begin
    win_d[0] = byte_i;
    for (int j = 1; j < TAG_MAX; j++) begin
      win_d[j] = win_q[j-1];
    end
  end

  assign seen_d = (seen_q == CNT_W'(TAG_MAX)) ? seen_q : seen_q + CNT_W'(1);

  // Entry j holds tag byte eff_len-1-j; entries past the tag always hit
  always_comb begin
    for (int j = 0; j < TAG_MAX; j++) begin
      hit[j] = (eff_len <= CNT_W'(j)) ||
               (win_d[j] == hdrx_pkg::tag_byte(tag_low_i, tag_high_i,
                  hdrx_pkg::TAG_IDX_W'(eff_len) - hdrx_pkg::TAG_IDX_W'(j)
                  - hdrx_pkg::TAG_IDX_W'(1)));
    end
  end

  assign match_o = (&hit) && (seen_d >= eff_len);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.push) begin
      for (int j = 0; j < TAG_MAX; j++) begin
        win_q[j] <= win_d[j];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= '0;
    end else if (ctrl_i.clear) begin
      seen_q <= '0;
    end else if (ctrl_i.push) begin
      seen_q <= seen_d;
    end
  end

endmodule

// ----- sv/hdrx_fsm.sv -----
`timescale 1ns / 1ps
// Message phase sequencer: search, skip to space, emit value, done.
// Depends on hdrx_pkg.
module hdrx_fsm (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                advance_i,
  input  logic [1:0]          mode_i,
  input  logic [7:0]          byte_i,
  input  logic                match_i,
  output hdrx_pkg::win_ctrl_t ctrl_o,
  output hdrx_pkg::res_t      res_o
);

  typedef enum logic [1:0] {
    PH_SEARCH = 2'd0,
    PH_SKIP   = 2'd1,
    PH_VALUE  = 2'd2,
    PH_DONE   = 2'd3
  } phase_e;

  phase_e              phase_q;
  phase_e              phase_d;
  hdrx_pkg::win_ctrl_t ctrl;

  always_comb begin
    phase_d     = phase_q;
    ctrl        = '0;
    res_o       = '0;
    res_o.kind  = hdrx_pkg::KIND_BYTE;
    case (mode_i)
      hdrx_pkg::MODE_START: begin
        ctrl.clear = 1'b1;
        phase_d    = PH_SEARCH;
      end
      hdrx_pkg::MODE_END: begin
        ctrl.clear = 1'b1;
        phase_d    = PH_SEARCH;
        if (phase_q == PH_SEARCH) begin
          res_o.valid = 1'b1;
          res_o.kind  = hdrx_pkg::KIND_NOT_FOUND;
        end else if (phase_q != PH_DONE) begin
          res_o.valid = 1'b1;
          res_o.kind  = hdrx_pkg::KIND_TRUNCATED;
        end
      end
      hdrx_pkg::MODE_DATA: begin
        case (phase_q)
          PH_SEARCH: begin
            ctrl.push = 1'b1;
            if (match_i) begin
              phase_d = PH_SKIP;
            end
          end
          PH_SKIP: begin
            if (byte_i == hdrx_pkg::CHAR_SPACE) begin
              phase_d = PH_VALUE;
            end
          end
          PH_VALUE: begin
            res_o.valid = 1'b1;
            if (byte_i == hdrx_pkg::CHAR_CR || byte_i == hdrx_pkg::CHAR_LF) begin
              phase_d    = PH_DONE;
              res_o.kind = hdrx_pkg::KIND_COMPLETE;
            end else begin
              res_o.value = byte_i;
            end
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  assign ctrl_o.push  = advance_i & ctrl.push;
  assign ctrl_o.clear = advance_i & ctrl.clear;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SEARCH;
    end else if (advance_i) begin
      phase_q <= phase_d;
    end
  end

endmodule

// ----- sv/header_tag_value_extractor_top.sv -----
`timescale 1ns / 1ps
// Header tag value extractor, top level: channel registers and config.
// Depends on hdrx_pkg, hdrx_window and hdrx_fsm.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one transaction per byte:
//   mode_i selects data byte, start of message or end of message. The block
//   looks for the configured tag in the byte stream, skips up to and
//   including the next space, then emits each value byte until CR or LF and
//   reports value complete. End of message reports tag not found, or value
//   truncated if the tag was found and no CR or LF had ended its value.
//   Output channel (out_valid_o / out_stall_i) carries result_kind_o and
//   value_byte_o; at most one result per input transaction.
//   Config port: cfg_we_i writes cfg_data_i to register cfg_idx_i (tag
//   length, tag bytes 0..7, tag bytes 8..15); write only while idle.
//   Path: a transaction is accepted into the input register; its result is
//   written into the result register when the transaction advances.
//   Throughput: one transaction per cycle while the output does not stall; the
//   window compare of all TAG_MAX positions against the tag is combinational.
//   Reset: phase returns to searching, the byte count clears, both channel
//   registers empty, tag length becomes one and the tag bytes zero.
//   Stall: a stalled result holds; the input register keeps one more
//   transaction, then in_stall_o rises until the result is taken.
module header_tag_value_extractor_top #(
  parameter int TAG_MAX = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [63:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  mode_i,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  result_kind_o,
  output logic [7:0]  value_byte_o
);

  // Configuration registers
  logic [4:0]  tag_length_q;
  logic [63:0] tag_low_q;
  logic [63:0] tag_high_q;

  // Input register
  logic       in_valid_q;
  logic [1:0] mode_q;
  logic [7:0] byte_q;

  // Result register
  logic            out_valid_q;
  hdrx_pkg::kind_e out_kind_q;
  logic [7:0]      out_byte_q;

  logic                advance;
  logic                in_accept;
  logic                match;
  hdrx_pkg::win_ctrl_t win_ctrl;
  hdrx_pkg::res_t      res;

  // Advance the held transaction when the result register is free or draining
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_length_q <= 5'd1;
      tag_low_q    <= '0;
      tag_high_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        hdrx_pkg::CFG_TAG_LENGTH: tag_length_q <= cfg_data_i[4:0];
        hdrx_pkg::CFG_TAG_LOW:    tag_low_q    <= cfg_data_i;
        hdrx_pkg::CFG_TAG_HIGH:   tag_high_q   <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_accept) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  // Payload holds while stalled
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      mode_q <= mode_i;
      byte_q <= data_byte_i;
    end
  end

  hdrx_window #(
    .TAG_MAX(TAG_MAX)
  ) u_window (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (win_ctrl),
    .byte_i      (byte_q),
    .tag_length_i(tag_length_q),
    .tag_low_i   (tag_low_q),
    .tag_high_i  (tag_high_q),
    .match_o     (match)
  );

  hdrx_fsm u_fsm (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .advance_i(advance),
    .mode_i   (mode_q),
    .byte_i   (byte_q),
    .match_i  (match),
    .ctrl_o   (win_ctrl),
    .res_o    (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= res.valid;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_kind_q <= res.kind;
      out_byte_q <= res.value;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign result_kind_o = out_kind_q;
  assign value_byte_o  = out_byte_q;

  // A stall toward the sender only while a transaction waits in the input register
  assert property (@(posedge clk_i) disable iff (!rst_ni) in_stall_o |-> in_valid_q)
    else $error("input stall without a held transaction");

  // A new result only comes from an advanced transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(advance))
    else $error("result appeared without an advanced transaction");

  // Only value bytes carry a nonzero byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_kind_q != hdrx_pkg::KIND_BYTE) |-> (out_byte_q == 8'h00))
    else $error("nonzero byte on a status result");

  // The window never shifts and clears in the same cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(win_ctrl.push && win_ctrl.clear))
    else $error("window push and clear together");

endmodule
